### hw/rtl/etb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etb_pkg: shared definitions for the elimination tree builder
// Field widths, register indexes, mode and status codes, sequencer states.
// ----------------------------------------------------------------------------
package etb_pkg;

  localparam int unsigned MAX_DIM_DEF = 1024;

  localparam int unsigned IDX_W    = 10;  // row, column and node indices
  localparam int unsigned CNT_W    = 11;  // column and row count registers
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DATA_W   = 24;  // two indices, padded to bytes
  localparam int unsigned ENTRY_W  = IDX_W + 1;  // valid flag and column

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_MODE = 2'd2;

  // matrix modes
  localparam logic [MODE_W-1:0] MODE_ATA       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYM_UPPER = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_EDGE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MODE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd2;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_PROC     = 7'b0000100,
    ST_LAST_CHK = 7'b0001000,
    ST_WALK_RD  = 7'b0010000,
    ST_WALK_CHK = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } etb_state_t;

endpackage

### hw/rtl/elimination_tree_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elimination_tree_builder: elimination tree with path compression
// Takes nonzero positions (row, column), columns nondecreasing, and emits
// one (child, parent) transaction each time a node gains its parent.
//
// Usage:
//   s_* : one nonzero per transaction. tdata = row [9:0], column [19:10];
//         tuser = start_matrix, which clears both stores before the entry.
//   m_* : zero or one result per entry. tdata = child [9:0], parent [19:10];
//         tuser = status (0 edge, 1 unsupported mode, 2 index out of range).
//   cfg_* : register writes (0 num_columns, 1 num_rows, 2 matrix_mode),
//         always ready; write only while the block is idle.
// Timing: s_tready is high only while the sequencer is idle. An entry passes
//   the checks, then in A'A mode the per-row column read, then for each
//   ancestor link visited a registered read and a compare/write of the
//   ancestor RAM, and, when a result is produced, the load of the output
//   register. Path compression keeps the walk short on average.
//   A start_matrix entry first runs a clearing pass over all MAX_DIM addresses.
// Reset: after rst the same clearing pass runs before the
//   first entry is taken. A stalled receiver holds the result in the output
//   register; the next entry is still taken and waits only to emit.
// ----------------------------------------------------------------------------
module elimination_tree_builder #(
  parameter int unsigned MAX_DIM = etb_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // row [9:0], column [19:10], zeros above
  input  logic [etb_pkg::DATA_W-1:0]     s_tdata,
  // start_matrix [0]
  input  logic [0:0]                     s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // child_node [9:0], parent_node [19:10], zeros above
  output logic [etb_pkg::DATA_W-1:0]     m_tdata,
  // status [1:0]
  output logic [etb_pkg::STATUS_W-1:0]   m_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [etb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etb_pkg::CNT_W-1:0]      cfg_data
);

  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned SW = $clog2(MAX_DIM + 2);
  localparam int unsigned IW = etb_pkg::IDX_W;
  localparam int unsigned EW = etb_pkg::ENTRY_W;

  etb_pkg::etb_state_t state, state_next;

  logic [etb_pkg::CNT_W-1:0]    num_columns;
  logic [etb_pkg::CNT_W-1:0]    num_rows;
  logic [etb_pkg::MODE_W-1:0]   matrix_mode;

  logic [IW-1:0] row, row_next;
  logic [IW-1:0] col, col_next;
  logic          start_pend, start_pend_next;
  logic [IW-1:0] node, node_next;
  logic [SW-1:0] steps, steps_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;

  logic [IW-1:0]                res_child, res_child_next;
  logic [IW-1:0]                res_parent, res_parent_next;
  logic [etb_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic [EW-1:0] anc_mem [MAX_DIM];
  logic [EW-1:0] last_mem [MAX_DIM];
  logic [EW-1:0] anc_q, last_q;
  logic          anc_we, last_we;
  logic [AW-1:0] anc_waddr, last_waddr;
  logic [EW-1:0] anc_wdata, last_wdata;

  logic          s_acc, out_load;
  logic          mode_ok, col_ok, row_ok;
  logic [etb_pkg::CNT_W-1:0] row_lim;

  assign s_tready  = (state == etb_pkg::ST_IDLE);
  assign s_acc     = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= etb_pkg::CNT_W'(1024);
      num_rows    <= etb_pkg::CNT_W'(1024);
      matrix_mode <= etb_pkg::MODE_ATA;
    end else if (cfg_valid) begin
      case (cfg_index)
        etb_pkg::REG_NUM_COLUMNS: num_columns <= cfg_data;
        etb_pkg::REG_NUM_ROWS:    num_rows    <= cfg_data;
        etb_pkg::REG_MATRIX_MODE: matrix_mode <= cfg_data[etb_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    anc_q <= anc_mem[AW'(node)];
  end

  always_ff @(posedge clk) begin
    if (last_we) last_mem[last_waddr] <= last_wdata;
    last_q <= last_mem[AW'(row)];
  end

  assign mode_ok = matrix_mode inside {etb_pkg::MODE_ATA, etb_pkg::MODE_SYM_UPPER};
  assign row_lim = (matrix_mode == etb_pkg::MODE_ATA) ? num_rows : num_columns;
  assign col_ok  = ({1'b0, col} < num_columns) && (32'(col) < MAX_DIM);
  assign row_ok  = ({1'b0, row} < row_lim) && (32'(row) < MAX_DIM);

  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    start_pend_next = start_pend;
    node_next       = node;
    steps_next      = steps;
    clr_cnt_next    = clr_cnt;
    res_child_next  = res_child;
    res_parent_next = res_parent;
    res_status_next = res_status;
    anc_we          = 1'b0;
    anc_waddr       = AW'(node);
    anc_wdata       = {1'b1, col};
    last_we         = 1'b0;
    last_waddr      = AW'(row);
    last_wdata      = {1'b1, col};
    out_load        = 1'b0;

    case (state)
      etb_pkg::ST_CLEAR: begin
        anc_we     = 1'b1;
        anc_waddr  = clr_cnt;
        anc_wdata  = '0;
        last_we    = 1'b1;
        last_waddr = clr_cnt;
        last_wdata = '0;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(MAX_DIM - 1)) begin
          clr_cnt_next = '0;
          state_next   = start_pend ? etb_pkg::ST_PROC : etb_pkg::ST_IDLE;
          start_pend_next = 1'b0;
        end
      end
      etb_pkg::ST_IDLE: begin
        if (s_acc) begin
          row_next = s_tdata[IW-1:0];
          col_next = s_tdata[2*IW-1:IW];
          if (s_tuser[0]) begin
            start_pend_next = 1'b1;
            clr_cnt_next    = '0;
            state_next      = etb_pkg::ST_CLEAR;
          end else begin
            state_next = etb_pkg::ST_PROC;
          end
        end
      end
      etb_pkg::ST_PROC: begin
        res_child_next  = '0;
        res_parent_next = '0;
        if (!mode_ok) begin
          res_status_next = etb_pkg::STATUS_BAD_MODE;
          state_next      = etb_pkg::ST_EMIT;
        end else if (!col_ok || !row_ok) begin
          res_status_next = etb_pkg::STATUS_OUT_RANGE;
          state_next      = etb_pkg::ST_EMIT;
        end else if (matrix_mode == etb_pkg::MODE_SYM_UPPER) begin
          node_next  = row;
          steps_next = '0;
          state_next = (row < col) ? etb_pkg::ST_WALK_RD : etb_pkg::ST_IDLE;
        end else begin
          state_next = etb_pkg::ST_LAST_CHK;
        end
      end
      etb_pkg::ST_LAST_CHK: begin
        last_we    = 1'b1;
        node_next  = last_q[IW-1:0];
        steps_next = '0;
        if (last_q[IW] && (last_q[IW-1:0] < col)) begin
          state_next = etb_pkg::ST_WALK_RD;
        end else begin
          state_next = etb_pkg::ST_IDLE;
        end
      end
      etb_pkg::ST_WALK_RD: begin
        state_next = etb_pkg::ST_WALK_CHK;
      end
      etb_pkg::ST_WALK_CHK: begin
        if ((32'(node) >= MAX_DIM) || (steps == SW'(MAX_DIM + 1))) begin
          state_next = etb_pkg::ST_IDLE;
        end else if (anc_q[IW] && (anc_q[IW-1:0] == col)) begin
          state_next = etb_pkg::ST_IDLE;
        end else begin
          anc_we = 1'b1;
          if (!anc_q[IW]) begin
            res_child_next  = node;
            res_parent_next = col;
            res_status_next = etb_pkg::STATUS_EDGE;
            state_next      = etb_pkg::ST_EMIT;
          end else begin
            node_next  = anc_q[IW-1:0];
            steps_next = steps + SW'(1);
            state_next = etb_pkg::ST_WALK_RD;
          end
        end
      end
      etb_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = etb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = etb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= etb_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      start_pend <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      start_pend <= start_pend_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    row        <= row_next;
    col        <= col_next;
    node       <= node_next;
    steps      <= steps_next;
    res_child  <= res_child_next;
    res_parent <= res_parent_next;
    res_status <= res_status_next;
    if (out_load) begin
      m_tdata <= {(etb_pkg::DATA_W - 2 * IW)'(0), res_parent, res_child};
      m_tuser <= res_status;
    end
  end

endmodule
